/* rtl/ftbc_pkg.sv */
// shared types and constants for the fractional tick bcd clock
// no dependencies; imported by every module of the block
package ftbc_pkg;

   // configuration register widths and reset values
   localparam int IncWidth      = 10;
   localparam int ThrWidth      = 16;
   localparam int AccWidth      = 17;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 16;
   localparam int DigitWidth    = 4;
   localparam int NumDigits     = 6;
   localparam int ReqDataWidth  = 8;
   localparam int RspDataWidth  = 40;

   localparam logic [IncWidth-1:0] IncReset = 10'd256;
   localparam logic [ThrWidth-1:0] ThrReset = 16'd1953;
   localparam logic [AccWidth-1:0] AccMax   = 17'h1FFFF;

   // register indexes on the csr channel
   typedef enum logic [CsrIndexWidth-1:0] {
      REG_OVERFLOW_INCREMENT = 2'd0,
      REG_TICKS_PER_SECOND   = 2'd1
   } reg_index_type;

   // one configuration write as seen by the accumulator
   typedef struct packed {
      logic                     write;
      logic [CsrIndexWidth-1:0] index;
      logic [CsrDataWidth-1:0]  data;
   } csr_write_type;

   typedef logic [DigitWidth-1:0] digit_type;

   // digit order in the cell row: seconds units first, hours tens last
   localparam int DigSecUnits  = 0;
   localparam int DigSecTens   = 1;
   localparam int DigMinUnits  = 2;
   localparam int DigMinTens   = 3;
   localparam int DigHourUnits = 4;
   localparam int DigHourTens  = 5;

   // largest value of each digit before it wraps
   localparam digit_type DigitMax [NumDigits] = '{
      4'd9, 4'd5, 4'd9, 4'd5, 4'd9, 4'd2
   };

   // time after reset: 12:03:00
   localparam digit_type DigitReset [NumDigits] = '{
      4'd0, 4'd0, 4'd3, 4'd0, 4'd2, 4'd1
   };

   // hours wrap from 23 to 00
   localparam digit_type HourTensLast  = 4'd2;
   localparam digit_type HourUnitsLast = 4'd3;

endpackage

/* rtl/fractional_tick_bcd_clock.sv */
// top level of the fractional tick bcd clock
// depends on ftbc_pkg, ftbc_tick_accum and ftbc_digit_cell
//
// usage:
//   req channel: one request per main-loop pass, req_tdata[0] set when the
//   timer overflowed during that pass.
//   rsp channel: exactly one response per request, holding the clock digits,
//   the second pulse, the blink bit and the accumulator remainder after it.
//   csr channel: csr_index 0 writes overflow_increment, 1 ticks_per_second;
//   other indexes are dropped. always ready; write only while idle.
// timing and throughput:
//   the response appears in the cycle after its request is taken. one
//   request per cycle is sustained while rsp_tready holds: the accumulator
//   add-compare-subtract and the six-cell carry ripple are combinational.
// reset:
//   synchronous, active high. time returns to 12:03:00, blink to 1, the
//   accumulator to 0 and both registers to their defaults (256, 1953).
// stalls:
//   the response sits in an output register; while it is not taken, a new
//   request is only taken in the cycle the receiver takes the old one.
module fractional_tick_bcd_clock
   import ftbc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // request: [0] timer_overflow, [7:1] zero
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [ReqDataWidth-1:0]  req_tdata,
   // response: [1:0] hour_tens, [5:2] hour_units, [8:6] minute_tens,
   // [12:9] minute_units, [15:13] second_tens, [19:16] second_units,
   // [20] second_pulse, [21] blink, [38:22] fraction_count, [39] zero
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RspDataWidth-1:0]  rsp_tdata,
   // configuration writes
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data
);

   logic                    accept;
   logic                    tick;
   logic [AccWidth-1:0]     acc_in;
   csr_write_type           csr_write;
   logic [NumDigits-1:0]    carry;
   logic                    hour_wrap;
   digit_type               digit_in [NumDigits];
   digit_type               digit_ff [NumDigits];
   logic                    blink_ff;
   logic                    blink_in;
   logic                    rsp_valid_ff;
   logic [RspDataWidth-1:0] rsp_data_ff;
   logic [RspDataWidth-1:0] rsp_data_in;

   // handshakes
   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign csr_write.write = csr_valid;
   assign csr_write.index = csr_index;
   assign csr_write.data  = csr_data;

   ftbc_tick_accum u_accum (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .accept         (accept),
      .timer_overflow (req_tdata[0]),
      .tick           (tick),
      .acc_in         (acc_in)
   );

   // carry handed from each cell to the next one up
   always_comb begin
      carry[0] = accept && tick;
      for (int i = 1; i < NumDigits; i++) begin
         carry[i] = carry[i-1] && (digit_ff[i-1] == DigitMax[i-1]);
      end
   end

   // 23:59:59 rolls to 00:00:00
   assign hour_wrap = carry[DigHourUnits]
                      && (digit_ff[DigHourTens] == HourTensLast)
                      && (digit_ff[DigHourUnits] == HourUnitsLast);

   for (genvar g = 0; g < NumDigits; g++) begin : g_cell
      ftbc_digit_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .reset_digit (DigitReset[g]),
         .max_digit   (DigitMax[g]),
         .step        (carry[g]),
         .clear       (hour_wrap && (g >= DigHourUnits)),
         .digit_in    (digit_in[g]),
         .digit_ff    (digit_ff[g])
      );
   end

   // blink flips once per second
   assign blink_in = blink_ff ^ carry[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         blink_ff <= 1'b1;
      end else begin
         blink_ff <= blink_in;
      end
   end

   // response packing
   assign rsp_data_in = {1'b0,
                         acc_in,
                         blink_in,
                         tick,
                         digit_in[DigSecUnits],
                         digit_in[DigSecTens][2:0],
                         digit_in[DigMinUnits],
                         digit_in[DigMinTens][2:0],
                         digit_in[DigHourUnits],
                         digit_in[DigHourTens][1:0]};

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* rtl/ftbc_digit_cell.sv */
// one bcd digit of the clock: holds the digit and steps it on a carry
// depends on ftbc_pkg
module ftbc_digit_cell
   import ftbc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  digit_type reset_digit,
   input  digit_type max_digit,
   input  logic      step,
   input  logic      clear,
   output digit_type digit_in,
   output digit_type digit_ff
);

   // increment with wrap, clear overrides
   always_comb begin
      digit_in = digit_ff;
      if (clear) begin
         digit_in = '0;
      end else if (step) begin
         if (digit_ff == max_digit) begin
            digit_in = '0;
         end else begin
            digit_in = digit_ff + digit_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_ff <= reset_digit;
      end else begin
         digit_ff <= digit_in;
      end
   end

endmodule

/* rtl/ftbc_tick_accum.sv */
// fractional accumulator and its two configuration registers
// depends on ftbc_pkg
module ftbc_tick_accum
   import ftbc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  csr_write_type       csr_write,
   input  logic                accept,
   input  logic                timer_overflow,
   output logic                tick,
   output logic [AccWidth-1:0] acc_in
);

   logic [IncWidth-1:0] inc_ff;
   logic [ThrWidth-1:0] thr_ff;
   logic [AccWidth-1:0] acc_ff;
   logic [AccWidth:0]   sum;
   logic [AccWidth-1:0] sat;

   // configuration registers, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         inc_ff <= IncReset;
         thr_ff <= ThrReset;
      end else if (csr_write.write) begin
         unique case (csr_write.index)
            REG_OVERFLOW_INCREMENT: inc_ff <= csr_write.data[IncWidth-1:0];
            REG_TICKS_PER_SECOND:   thr_ff <= csr_write.data[ThrWidth-1:0];
            default: ;
         endcase
      end
   end

   // saturating add on timer overflow, then one threshold compare and subtract
   always_comb begin
      sum = {1'b0, acc_ff} + (AccWidth+1)'(inc_ff);
      sat = acc_ff;
      if (timer_overflow) begin
         sat = sum[AccWidth] ? AccMax : sum[AccWidth-1:0];
      end
      tick   = (sat >= AccWidth'(thr_ff));
      acc_in = tick ? (sat - AccWidth'(thr_ff)) : sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (accept) begin
         acc_ff <= acc_in;
      end
   end

endmodule
